// ===== rtl/ird_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse-distance decoder package
// Shared types and constants: request and result payloads, codes, resets.
// ----------------------------------------------------------------------------
package ird_pkg;

  // Request command codes
  localparam logic CmdEdge  = 1'b0;
  localparam logic CmdFlush = 1'b1;

  // Result kind codes
  localparam logic [1:0] KindByte  = 2'd0;
  localparam logic [1:0] KindError = 2'd1;
  localparam logic [1:0] KindEnd   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] RegHeader = 2'd0;
  localparam logic [1:0] RegOne    = 2'd1;
  localparam logic [1:0] RegZero   = 2'd2;

  // Threshold reset values, microseconds
  localparam logic [15:0] HeaderReset = 16'd3000;
  localparam logic [15:0] OneReset    = 16'd1000;
  localparam logic [15:0] ZeroReset   = 16'd600;

  // Intervals skipped at the start of a capture and after a header
  localparam logic [1:0] SkipCount = 2'd2;

  // Bits in a complete byte
  localparam logic [3:0] FullByteBits = 4'd8;

  typedef struct packed {
    logic [15:0] header_threshold;
    logic [15:0] one_threshold;
    logic [15:0] zero_threshold;
  } cfg_t;

  typedef struct packed {
    logic        command;
    logic [31:0] timestamp_us;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [4:0]  byte_index;
    logic [3:0]  bit_count;
    logic [31:0] error_high;
  } res_t;

endpackage

// ===== rtl/ird_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying edge and flush requests.
// ----------------------------------------------------------------------------
interface ird_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] timestamp_us;

  modport source (output valid, output command, output timestamp_us, input ready);
  modport sink   (input valid, input command, input timestamp_us, output ready);
endinterface

// ===== rtl/ird_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying decoded bytes, frame errors and end markers.
// ----------------------------------------------------------------------------
interface ird_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_value;
  logic [4:0]  byte_index;
  logic [3:0]  bit_count;
  logic [31:0] error_high;

  modport source (output valid, output kind, output byte_value, output byte_index,
                  output bit_count, output error_high, input ready);
  modport sink   (input valid, input kind, input byte_value, input byte_index,
                  input bit_count, input error_high, output ready);
endinterface

// ===== rtl/ird_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold registers
// Write-only threshold registers; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module ird_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           we_i,
  input  logic [1:0]     index_i,
  input  logic [15:0]    wdata_i,
  output ird_pkg::cfg_t  cfg_o
);

  ird_pkg::cfg_t cfg_q, cfg_d;

  // Register decode
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (index_i)
        ird_pkg::RegHeader: cfg_d.header_threshold = wdata_i;
        ird_pkg::RegOne:    cfg_d.one_threshold    = wdata_i;
        ird_pkg::RegZero:   cfg_d.zero_threshold   = wdata_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_threshold <= ird_pkg::HeaderReset;
      cfg_q.one_threshold    <= ird_pkg::OneReset;
      cfg_q.zero_threshold   <= ird_pkg::ZeroReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/ird_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request register
// Captures one request per cycle while the decoder keeps taking them, and holds each until the decoder takes it.
// ----------------------------------------------------------------------------
module ird_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  ird_pkg::req_t  req_i,
  output logic           valid_o,
  input  logic           ready_i,
  output ird_pkg::req_t  req_o
);

  logic          valid_q, valid_d;
  ird_pkg::req_t req_q;
  logic          load;

  // Free when empty or when the held request moves on this cycle
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

// ===== rtl/ird_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder core
// Interval measurement, pair classification, bit packing and result register.
// ----------------------------------------------------------------------------
module ird_core #(
  parameter int unsigned MAX_INTERVALS = 1024,
  parameter int unsigned MAX_BYTES     = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ird_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  ird_pkg::req_t  req_i,
  output logic           valid_o,
  input  logic           ready_i,
  output ird_pkg::res_t  res_o
);

  localparam int unsigned CntW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned PosW = $clog2(MAX_BYTES + 1);

  // Capture state
  logic [31:0]     last_time_q, last_time_d;
  logic            have_last_q, have_last_d;
  logic [CntW-1:0] icount_q, icount_d;
  logic [1:0]      skip_q, skip_d;
  logic            second_q, second_d;
  logic            low_zero_q, low_zero_d;
  logic            stopped_q, stopped_d;
  logic [2:0]      bit_pos_q, bit_pos_d;
  logic [7:0]      acc_q, acc_d;
  logic [PosW-1:0] byte_pos_q, byte_pos_d;

  // Result register
  logic          out_valid_q, out_valid_d;
  ird_pkg::res_t res_q, res_d;
  logic          res_hit;

  logic        take;
  logic        step;
  logic [31:0] iv;
  logic        iv_zero;
  logic        push;
  logic        push_one;
  logic [7:0]  acc_new;

  assign take    = !out_valid_q || ready_i;
  assign ready_o = take;
  assign step    = valid_i && take;

  assign iv      = req_i.timestamp_us - last_time_q;
  assign iv_zero = (iv == 32'd0);
  assign acc_new = push_one ? (acc_q | (8'd1 << bit_pos_q)) : acc_q;

  // Per-request state update and result selection
  always_comb begin
    last_time_d = last_time_q;
    have_last_d = have_last_q;
    icount_d    = icount_q;
    skip_d      = skip_q;
    second_d    = second_q;
    low_zero_d  = low_zero_q;
    stopped_d   = stopped_q;
    bit_pos_d   = bit_pos_q;
    acc_d       = acc_q;
    byte_pos_d  = byte_pos_q;
    res_hit     = 1'b0;
    res_d       = '0;
    push        = 1'b0;
    push_one    = 1'b0;

    if (req_i.command == ird_pkg::CmdFlush) begin
      res_hit          = 1'b1;
      res_d.kind       = ird_pkg::KindEnd;
      res_d.byte_value = acc_q;
      res_d.byte_index = 5'(byte_pos_q);
      res_d.bit_count  = {1'b0, bit_pos_q};
      last_time_d = '0;
      have_last_d = 1'b0;
      icount_d    = '0;
      skip_d      = ird_pkg::SkipCount;
      second_d    = 1'b0;
      low_zero_d  = 1'b0;
      stopped_d   = 1'b0;
      bit_pos_d   = '0;
      acc_d       = '0;
      byte_pos_d  = '0;
    end else if (!have_last_q) begin
      have_last_d = 1'b1;
      last_time_d = req_i.timestamp_us;
    end else begin
      last_time_d = req_i.timestamp_us;
      if (icount_q != CntW'(MAX_INTERVALS)) begin
        icount_d = icount_q + CntW'(1);
        if (skip_q != 2'd0) begin
          skip_d = skip_q - 2'd1;
        end else if (!stopped_q) begin
          if (!second_q) begin
            low_zero_d = iv_zero;
            second_d   = 1'b1;
          end else begin
            second_d = 1'b0;
            if (low_zero_q || iv_zero) begin
              stopped_d = 1'b1;
            end else if (iv > {16'd0, cfg_i.header_threshold}) begin
              skip_d = ird_pkg::SkipCount;
            end else if (iv > {16'd0, cfg_i.one_threshold}) begin
              push     = 1'b1;
              push_one = 1'b1;
            end else if (iv < {16'd0, cfg_i.zero_threshold}) begin
              push = 1'b1;
            end else begin
              res_hit          = 1'b1;
              res_d.kind       = ird_pkg::KindError;
              res_d.error_high = iv;
            end
          end
        end
      end
    end

    // Bit packing; bits past the byte limit are dropped
    if (push && (byte_pos_q != PosW'(MAX_BYTES))) begin
      if (bit_pos_q == 3'd7) begin
        res_hit          = 1'b1;
        res_d.kind       = ird_pkg::KindByte;
        res_d.byte_value = acc_new;
        res_d.byte_index = 5'(byte_pos_q);
        res_d.bit_count  = ird_pkg::FullByteBits;
        byte_pos_d       = byte_pos_q + PosW'(1);
        acc_d            = '0;
        bit_pos_d        = '0;
      end else begin
        acc_d     = acc_new;
        bit_pos_d = bit_pos_q + 3'd1;
      end
    end
  end

  // Output valid follows the result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = valid_i && res_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      have_last_q <= 1'b0;
      icount_q    <= '0;
      skip_q      <= ird_pkg::SkipCount;
      second_q    <= 1'b0;
      low_zero_q  <= 1'b0;
      stopped_q   <= 1'b0;
      bit_pos_q   <= '0;
      acc_q       <= '0;
      byte_pos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        last_time_q <= last_time_d;
        have_last_q <= have_last_d;
        icount_q    <= icount_d;
        skip_q      <= skip_d;
        second_q    <= second_d;
        low_zero_q  <= low_zero_d;
        stopped_q   <= stopped_d;
        bit_pos_q   <= bit_pos_d;
        acc_q       <= acc_d;
        byte_pos_q  <= byte_pos_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (step && res_hit) begin
      res_q <= res_d;
    end
  end

  assign valid_o = out_valid_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/ir_pulse_distance_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse-distance decoder
// Turns edge timestamps into decoded bytes, frame errors and end markers.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries requests: command edge with a microsecond timestamp, or
//   command flush, which ends the capture. out_o reports one result per
//   completed byte, per frame error and per flush; most edges give none.
//   Thresholds are written through cfg_we_i / cfg_index_i / cfg_wdata_i
//   while the block is idle; unknown indexes are ignored.
// Timing:
//   One request per cycle sustained while the receiver takes results. A
//   request is registered in the request register, then decoded into the
//   result register, from which its result is offered on out_o. The
//   interval subtract and the threshold compares set the cycle.
// Reset and stalls:
//   Reset clears the capture and restores the default thresholds. While
//   the receiver stalls, one held result plus one registered request are
//   kept; in_i.ready then drops and nothing is lost.
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder #(
  parameter int unsigned MAX_INTERVALS = 1024,
  parameter int unsigned MAX_BYTES     = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ird_in_if.sink        in_i,
  ird_out_if.source     out_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_wdata_i
);

  ird_pkg::cfg_t cfg;
  ird_pkg::req_t req_in, req_s1;
  ird_pkg::res_t res;
  logic          s1_valid;
  logic          s1_ready;

  assign req_in.command      = in_i.command;
  assign req_in.timestamp_us = in_i.timestamp_us;

  ird_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  ird_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .req_i   (req_in),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .req_o   (req_s1)
  );

  ird_core #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .MAX_BYTES     (MAX_BYTES)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .req_i   (req_s1),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res)
  );

  assign out_o.kind       = res.kind;
  assign out_o.byte_value = res.byte_value;
  assign out_o.byte_index = res.byte_index;
  assign out_o.bit_count  = res.bit_count;
  assign out_o.error_high = res.error_high;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse-distance decoder testbench
// Sends edge and flush requests through the valid/ready channels. A decode
// model kept alongside the block predicts every byte, frame error and end
// marker, and each result is compared with the oldest prediction. Directed
// frames cover threshold edges, headers, zero intervals and the capture
// limits. Random frames follow under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MaxIntervals  = 1024;
  localparam int unsigned MaxBytes      = 32;
  localparam int          SettleCycles  = 4;
  localparam int          HoldOffCycles = 400;
  localparam logic [1:0]  RegUnused     = 2'd3;

  // Classes of high interval used when building frames
  typedef enum int {
    HighOne,
    HighZero,
    HighHeader,
    HighError,
    HighStop,
    HighAny
  } high_class_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_wdata_i;

  ird_in_if  req_if ();
  ird_out_if res_if ();

  ir_pulse_distance_decoder #(
    .MAX_INTERVALS(MaxIntervals),
    .MAX_BYTES    (MaxBytes)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_if),
    .out_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Decode model: thresholds and capture state
  logic [15:0]   header_thr;
  logic [15:0]   one_thr;
  logic [15:0]   zero_thr;
  logic [31:0]   prev_edge_us;
  logic          edge_seen;
  logic [10:0]   intervals_used;
  logic [1:0]    skips_left;
  logic          awaiting_high;
  logic          low_zero;
  logic          decode_halted;
  logic [2:0]    bits_held;
  logic [7:0]    byte_shift;
  logic [5:0]    bytes_done;
  ird_pkg::res_t pending_results[$];

  // Stimulus bookkeeping
  logic [31:0] last_edge_us;
  int          requests_sent  = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          mismatches     = 0;
  int          hold_off_asks  = 0;
  int          hold_off_taken = 0;
  int          hold_left      = 0;
  logic [31:0] probe_highs [0:7] = '{32'd1, 32'd599, 32'd600, 32'd1000, 32'd1001,
                                     32'd65535, 32'd65536, 32'hFFFF_FFFF};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Decode model
  // --------------------------------------------------------------------------
  function automatic ird_pkg::res_t make_result(input logic [1:0] kind,
                                                input logic [7:0] value,
                                                input logic [4:0] index,
                                                input logic [3:0] count,
                                                input logic [31:0] err);
    ird_pkg::res_t r;
    r.kind       = kind;
    r.byte_value = value;
    r.byte_index = index;
    r.bit_count  = count;
    r.error_high = err;
    return r;
  endfunction

  task automatic clear_capture_model();
    prev_edge_us   = 32'd0;
    edge_seen      = 1'b0;
    intervals_used = 11'd0;
    skips_left     = ird_pkg::SkipCount;
    awaiting_high  = 1'b0;
    low_zero       = 1'b0;
    decode_halted  = 1'b0;
    bits_held      = 3'd0;
    byte_shift     = 8'd0;
    bytes_done     = 6'd0;
  endtask

  // LSB-first packing; bits beyond the byte limit are dropped
  task automatic store_bit(input logic b);
    if (bytes_done < MaxBytes) begin
      byte_shift[bits_held] = b;
      if (bits_held == 3'd7) begin
        pending_results.push_back(make_result(ird_pkg::KindByte, byte_shift,
                                              bytes_done[4:0], ird_pkg::FullByteBits,
                                              32'd0));
        bytes_done = bytes_done + 6'd1;
        byte_shift = 8'd0;
        bits_held  = 3'd0;
      end else begin
        bits_held = bits_held + 3'd1;
      end
    end
  endtask

  task automatic decode_request(input logic cmd, input logic [31:0] ts);
    logic [31:0] gap_us;
    if (cmd == ird_pkg::CmdFlush) begin
      pending_results.push_back(make_result(ird_pkg::KindEnd, byte_shift, bytes_done[4:0],
                                            {1'b0, bits_held}, 32'd0));
      clear_capture_model();
    end else if (!edge_seen) begin
      edge_seen    = 1'b1;
      prev_edge_us = ts;
    end else begin
      gap_us       = ts - prev_edge_us;
      prev_edge_us = ts;
      if (intervals_used < MaxIntervals) begin
        intervals_used = intervals_used + 11'd1;
        if (skips_left != 2'd0) begin
          skips_left = skips_left - 2'd1;
        end else if (!decode_halted) begin
          if (!awaiting_high) begin
            low_zero      = (gap_us == 32'd0);
            awaiting_high = 1'b1;
          end else begin
            awaiting_high = 1'b0;
            // zero-interval halt, then header, one, zero in that order; the first match wins
            if (low_zero || gap_us == 32'd0) begin
              decode_halted = 1'b1;
            end else if (gap_us > {16'd0, header_thr}) begin
              skips_left = ird_pkg::SkipCount;
            end else if (gap_us > {16'd0, one_thr}) begin
              store_bit(1'b1);
            end else if (gap_us < {16'd0, zero_thr}) begin
              store_bit(1'b0);
            end else begin
              pending_results.push_back(make_result(ird_pkg::KindError, 8'd0, 5'd0, 4'd0,
                                                    gap_us));
            end
          end
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  task automatic send_request(input logic cmd, input logic [31:0] ts);
    req_if.valid        <= 1'b1;
    req_if.command      <= cmd;
    req_if.timestamp_us <= ts;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    decode_request(cmd, ts);
    requests_sent++;
    if (cmd == ird_pkg::CmdEdge) last_edge_us = ts;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_gap(input logic [31:0] gap_us);
    send_request(ird_pkg::CmdEdge, last_edge_us + gap_us);
  endtask

  task automatic send_pair(input logic [31:0] low_us, input logic [31:0] high_us);
    send_gap(low_us);
    send_gap(high_us);
  endtask

  // First edge plus the two leading intervals that are skipped after a flush or reset
  task automatic open_capture(input logic [31:0] start_us);
    send_request(ird_pkg::CmdEdge, start_us);
    send_gap($urandom_range(20000, 1));
    send_gap($urandom_range(20000, 1));
  endtask

  // Drop valid and wait for every predicted result plus pipeline slack
  task automatic settle_block();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_thresholds(input logic [15:0] h, input logic [15:0] o,
                                    input logic [15:0] z);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= ird_pkg::RegHeader;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_index_i <= ird_pkg::RegOne;
    cfg_wdata_i <= o;
    @(posedge clk_i);
    cfg_index_i <= ird_pkg::RegZero;
    cfg_wdata_i <= z;
    @(posedge clk_i);
    // unknown index must leave every threshold alone
    cfg_index_i <= RegUnused;
    cfg_wdata_i <= 16'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    header_thr = h;
    one_thr    = o;
    zero_thr   = z;
  endtask

  function automatic logic [31:0] pick_low();
    int r;
    r = $urandom_range(99);
    if (r < 3) return 32'd0;
    if (r < 6) return $urandom;
    return $urandom_range(2000, 1);
  endfunction

  function automatic high_class_e pick_class();
    int r;
    r = $urandom_range(99);
    if (r < 40) return HighOne;
    if (r < 80) return HighZero;
    if (r < 86) return HighHeader;
    if (r < 93) return HighError;
    if (r < 96) return HighStop;
    return HighAny;
  endfunction

  // High interval aimed at a class under the current thresholds
  function automatic logic [31:0] pick_high(input high_class_e c);
    case (c)
      HighOne: begin
        if (one_thr < header_thr)
          return $urandom_range({16'd0, header_thr}, {16'd0, one_thr} + 32'd1);
        return $urandom;
      end
      HighZero: begin
        if (zero_thr > 16'd1) return $urandom_range({16'd0, zero_thr} - 32'd1, 1);
        return 32'd1;
      end
      HighHeader: return {16'd0, header_thr} + $urandom_range(50000, 1);
      HighError: begin
        if (zero_thr <= one_thr) return $urandom_range({16'd0, one_thr}, {16'd0, zero_thr});
        return {16'd0, zero_thr};
      end
      HighStop: return 32'd0;
      default:  return $urandom;
    endcase
  endfunction

  // Frame with random pair content; sometimes left without a flush
  task automatic send_capture();
    int n_pairs;
    n_pairs = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(20, 1);
    open_capture($urandom);
    repeat (n_pairs) send_pair(pick_low(), pick_high(pick_class()));
    if ($urandom_range(9) != 0) send_request(ird_pkg::CmdFlush, $urandom);
  endtask

  task automatic drive_traffic(input int n_requests);
    int first;
    first = requests_sent;
    while (requests_sent - first < n_requests) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(4, 1)) send_request(1'($urandom_range(1)), $urandom);
      end else begin
        send_capture();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Empty flush, then one full byte across the timestamp wrap
  task automatic test_full_byte();
    send_request(ird_pkg::CmdFlush, 32'd0);
    open_capture(32'hFFFF_FE00);
    send_pair(32'd560, 32'd1690);
    send_pair(32'd560, 32'd599);
    send_pair(32'd560, 32'd1001);
    send_pair(32'd560, 32'd1);
    send_pair(32'd560, 32'd3000);
    send_pair(32'd560, 32'd2);
    send_pair(32'd560, 32'd300);
    send_pair(32'd560, 32'd2500);
    settle_block();
  endtask

  // Frame errors, headers, skipped zeros and both kinds of halt
  task automatic test_special_pairs();
    send_pair(32'd560, 32'd1000);
    send_pair(32'd560, 32'd600);
    send_pair(32'd560, 32'd3001);
    send_pair(32'd0, 32'd0);
    send_pair(32'd560, 32'hFFFF_FFFF);
    send_pair(32'd7, 32'd7);
    send_pair(32'd560, 32'd1690);
    send_pair(32'd0, 32'd1690);
    send_pair(32'd560, 32'd1000);
    send_request(ird_pkg::CmdFlush, $urandom);
    // first edge at time zero, then a zero high
    open_capture(32'd0);
    send_pair(32'd560, 32'd0);
    send_pair(32'd560, 32'd600);
    send_request(ird_pkg::CmdFlush, $urandom);
    settle_block();
  endtask

  task automatic test_threshold_extremes();
    send_idle_pct  = 26;
    recv_stall_pct = 26;
    for (int k = 0; k < 4; k++) begin
      case (k)
        0:       program_thresholds(16'd0, 16'd0, 16'd0);
        1:       program_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2:       program_thresholds(16'd500, 16'd2000, 16'd4000);
        default: program_thresholds(ird_pkg::HeaderReset, ird_pkg::OneReset,
                                    ird_pkg::ZeroReset);
      endcase
      open_capture($urandom);
      for (int i = 0; i < 8; i++) send_pair(32'd100, probe_highs[i]);
      send_pair(32'd100, 32'd0);
      send_request(ird_pkg::CmdFlush, $urandom);
      settle_block();
    end
  endtask

  // Byte limit, then the interval limit within one long capture
  task automatic test_capture_limits();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    open_capture(32'h8000_0000);
    repeat (270) send_pair(32'd560, pick_high($urandom_range(1) ? HighOne : HighZero));
    // errors still reported once bytes are full
    repeat (5) send_pair(32'd560, pick_high(HighError));
    repeat (230) send_pair(32'd560, pick_high(HighOne));
    // these straddle the interval limit
    repeat (10) send_pair(32'd560, pick_high(HighError));
    send_pair(32'd0, 32'd0);
    send_request(ird_pkg::CmdFlush, $urandom);
    settle_block();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_asks++;
    repeat (6) send_request(ird_pkg::CmdFlush, $urandom);
    repeat (3) send_capture();
    repeat (4) send_request(ird_pkg::CmdFlush, $urandom);
    // sender pauses until the backlog has drained
    settle_block();
    recv_stall_pct = 53;
    repeat (4) send_capture();
    settle_block();
  endtask

  task automatic test_random_traffic();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    program_thresholds(ird_pkg::HeaderReset, ird_pkg::OneReset, ird_pkg::ZeroReset);
    drive_traffic(125);
    settle_block();

    send_idle_pct = 53;
    program_thresholds(16'($urandom_range(8000, 2000)), 16'($urandom_range(2000, 500)),
                       16'($urandom_range(500, 200)));
    drive_traffic(125);
    settle_block();

    send_idle_pct  = 0;
    recv_stall_pct = 53;
    program_thresholds(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                       16'($urandom_range(65535)));
    drive_traffic(125);
    settle_block();

    send_idle_pct  = 26;
    recv_stall_pct = 26;
    program_thresholds(ird_pkg::HeaderReset, ird_pkg::OneReset, ird_pkg::ZeroReset);
    drive_traffic(125);
    settle_block();
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready pattern with an optional long hold-off
  // --------------------------------------------------------------------------
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_taken != hold_off_asks) begin
        hold_left      = HoldOffCycles;
        hold_off_taken = hold_off_asks;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    ird_pkg::res_t got;
    ird_pkg::res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = make_result(res_if.kind, res_if.byte_value, res_if.byte_index,
                        res_if.bit_count, res_if.error_high);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kind=%0d value=%02h index=%0d bits=%0d err=%0d",
                   $time, got.kind, got.byte_value, got.byte_index, got.bit_count,
                   got.error_high);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.byte_value !== want.byte_value ||
            got.byte_index !== want.byte_index || got.bit_count !== want.bit_count ||
            got.error_high !== want.error_high) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected kind=%0d value=%02h index=%0d bits=%0d err=%0d",
                     $time, want.kind, want.byte_value, want.byte_index, want.bit_count,
                     want.error_high);
            $display("%0t: actual   kind=%0d value=%02h index=%0d bits=%0d err=%0d",
                     $time, got.kind, got.byte_value, got.byte_index, got.bit_count,
                     got.error_high);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    req_if.valid        <= 1'b0;
    req_if.command      <= ird_pkg::CmdEdge;
    req_if.timestamp_us <= 32'd0;
    cfg_we_i            <= 1'b0;
    cfg_index_i         <= ird_pkg::RegHeader;
    cfg_wdata_i         <= 16'd0;
    header_thr   = ird_pkg::HeaderReset;
    one_thr      = ird_pkg::OneReset;
    zero_thr     = ird_pkg::ZeroReset;
    last_edge_us = 32'd0;
    clear_capture_model();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_full_byte();
    test_special_pairs();
    test_threshold_extremes();
    test_capture_limits();
    test_backpressure();
    test_random_traffic();

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * SettleCycles) @(posedge clk_i);
    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
